// ===== rtl/core/mpvp_pkg.sv =====
// shared types and constants for the minimum pulse pwm block
`timescale 1ns / 1ps
package mpvp_pkg;

  localparam int unsigned LevelW = 11;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned MinW   = 20;
  localparam logic [MinW-1:0] MinPulseReset = 20'd1250;

  typedef struct packed {
    logic [LevelW-1:0] requested_level;
    logic [TimeW-1:0]  timer_now;
  } in_beat_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] alarm_time;
    logic             alarm_in_future;
  } out_beat_t;

  // divider request and answer
  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] dividend;
    logic [LevelW+6-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/min_pulse_variable_period_pwm.sv =====
// top level: pwm alarm planner with variable period and minimum pulse
// flow: an input beat is planned and its result registered for steady or edge levels;
//   when a new period is needed the divider runs first
// one item at a time: not ready while an item is in work
// the new period comes from the 64-step serial divider
// reset: asynchronous active low; state cleared, min pulse back to 1250 ticks
`timescale 1ns / 1ps
module min_pulse_variable_period_pwm
  import mpvp_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [MinW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_data_o
);

  localparam logic [LevelW+6-1:0] MaxL = (LevelW+6)'(MAX_LEVEL);
  localparam logic [LevelW+6-1:0] HalfL = (LevelW+6)'(MAX_LEVEL / 2);

  typedef enum logic [1:0] {IDLE, DIV, FIN, OUT} state_e;

  state_e state_q;
  logic [MinW-1:0]   mp_q;
  logic              hp_q, on_q, upd_q;
  logic [LevelW+6-1:0] prev_q, lvl_q;
  logic [TimeW-1:0]  ntt_q, nat_q, per_q, now_q;
  out_beat_t         res_q;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [LevelW+6-1:0] lin;
  logic [TimeW-1:0]    mp, mp2, np, nat1;
  logic                need_div;

  // saturate level
  always_comb begin
    lin = (LevelW+6)'(in_data_i.requested_level);
    if (lin > MaxL) lin = MaxL;
  end

  assign mp  = TimeW'(mp_q);
  assign mp2 = {mp[TimeW-2:0], 1'b0};
  assign np  = drsp.quotient;
  assign need_div = (lin != prev_q) && (lin != '0) && (lin != MaxL);

  // divider start: dividend mp*MAX, divisor level or MAX-level
  always_comb begin
    dreq.start    = (state_q == IDLE) && in_valid_i && need_div;
    dreq.dividend = TimeW'(mp_q) * TimeW'(MAX_LEVEL);
    dreq.divisor  = (lin <= HalfL) ? lin : (MaxL - lin);
  end

  mpvp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // planning logic for one item; np valid only in FIN
  logic hp_d, on_d, upd_d;
  logic [TimeW-1:0] ntt_d, nat_d, per_d;
  logic [LevelW+6-1:0] l;
  always_comb begin
    l     = lvl_q;
    hp_d  = hp_q;
    on_d  = on_q;
    upd_d = upd_q;
    ntt_d = ntt_q;
    per_d = per_q;
    nat_d = nat_q + mp;
    nat1  = nat_q + mp;
    if (l == prev_q) begin
      if (!hp_q) begin
        if (l != '0) begin
          if (!upd_q) begin
            on_d = !on_q;
            if (on_q) begin
              ntt_d = ntt_q + per_q;
              if (ntt_d > nat1) upd_d = 1'b1;
            end
          end else if (nat1 > ntt_q) begin
            nat_d = ntt_q;
            upd_d = 1'b0;
          end
        end
      end else if (l != MaxL) begin
        if (!upd_q) begin
          on_d = !on_q;
          if (on_q) ntt_d = ntt_q + per_q;
          else if (per_q > mp2) upd_d = 1'b1;
        end else if (nat1 > ntt_q + per_q - mp) begin
          nat_d = ntt_q + per_q - mp;
          upd_d = 1'b0;
        end
      end
    end else if (l <= HalfL) begin
      if (l != '0) begin
        if (on_q) begin
          on_d  = 1'b0;
          ntt_d = nat1 + np - mp2;
          upd_d = ntt_d > nat1;
        end else if (!hp_q) begin
          ntt_d = (prev_q == '0) ? ntt_q + np : ntt_q + np - per_q;
          if (ntt_d > nat1) upd_d = 1'b1;
          else begin
            if (ntt_d + mp > nat1) nat_d = ntt_d;
            else begin
              on_d  = 1'b1;
              ntt_d = nat1 - mp;
            end
            upd_d = 1'b0;
          end
        end else begin
          ntt_d = ntt_q + np - mp2;
          if (ntt_d > nat1) upd_d = 1'b1;
          else nat_d = ntt_d;
        end
        per_d = np;
      end else begin
        if (on_q) begin
          on_d  = 1'b0;
          ntt_d = nat1 - mp2;
        end else if (!hp_q) ntt_d = ntt_q - per_q;
        else ntt_d = ntt_q - mp2;
      end
      hp_d = 1'b0;
    end else begin
      if (l != MaxL) begin
        if (!on_q) begin
          on_d  = 1'b1;
          ntt_d = nat1 - mp;
          upd_d = np > mp2;
        end else if (ntt_q + np > nat1 + mp) upd_d = 1'b1;
        else begin
          if (ntt_q + np > nat1) nat_d = ntt_q + np - mp;
          else begin
            on_d  = 1'b0;
            ntt_d = nat1;
          end
          upd_d = 1'b0;
        end
        per_d = np;
      end else if (!on_q) begin
        on_d  = 1'b1;
        ntt_d = nat1 - mp;
      end
      hp_d = 1'b1;
    end
  end

  // sequencer, state registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      mp_q    <= MinPulseReset;
      hp_q    <= 1'b0;
      on_q    <= 1'b0;
      upd_q   <= 1'b0;
      prev_q  <= '0;
      ntt_q   <= '0;
      nat_q   <= '0;
      per_q   <= '0;
      lvl_q   <= '0;
      now_q   <= '0;
      res_q   <= '0;
    end else begin
      if (cfg_we_i) mp_q <= cfg_wdata_i;
      case (state_q)
        IDLE: if (in_valid_i) begin
          lvl_q   <= lin;
          now_q   <= in_data_i.timer_now;
          state_q <= need_div ? DIV : FIN;
        end
        DIV: if (drsp.done) state_q <= FIN;
        FIN: begin
          hp_q    <= hp_d;
          on_q    <= on_d;
          upd_q   <= upd_d;
          ntt_q   <= ntt_d;
          nat_q   <= nat_d;
          per_q   <= per_d;
          prev_q  <= lvl_q;
          res_q.pin_level       <= on_d;
          res_q.alarm_time      <= nat_d;
          res_q.alarm_in_future <= nat_d > now_q;
          state_q <= OUT;
        end
        OUT: if (out_ready_i) state_q <= IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = (state_q == OUT);
  assign out_data_o  = res_q;

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");
  a_div_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV && drsp.done) |=> state_q == FIN) else $error("lost divider result");
  a_out_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FIN) |=> out_valid_o) else $error("result not shown");

endmodule

// ===== rtl/core/mpvp_divider.sv =====
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mpvp_divider
  import mpvp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned DW = LevelW + 6;

  logic [TimeW-1:0] quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DW:0]      trial;

  // shift in next dividend bit and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[TimeW-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'(TimeW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[TimeW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[TimeW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== dv/tb_min_pulse_variable_period_pwm.sv =====
// testbench for the minimum pulse variable period pwm alarm planner
`timescale 1ns / 1ps
module tb_min_pulse_variable_period_pwm;
  import mpvp_pkg::*;

  localparam int unsigned MaxLevel = 1024;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [MinW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_beat_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_beat_t       out_data_o;

  min_pulse_variable_period_pwm #(.MAX_LEVEL(MaxLevel)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  // predictor state
  logic [TimeW-1:0]  pw_min;
  logic              pw_high_mode, pw_pin_on, pw_updating;
  logic [LevelW-1:0] pw_prev_level;
  logic [TimeW-1:0]  pw_toggle_at, pw_alarm_at, pw_period;

  out_beat_t expected_beats[$];
  int unsigned n_errors = 0, n_beats = 0, n_sent = 0, n_late = 0;
  bit quiet = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("min_pulse_variable_period_pwm test failed");
    $finish;
  end

  task automatic report(input string what);
    n_errors++;
    $display("mismatch: %s", what);
  endtask

  // continue the running cycle at an unchanged level
  function automatic void steady_step(input logic [LevelW-1:0] lvl);
    logic [TimeW-1:0] off_at;
    if (!pw_high_mode) begin
      if (lvl == 0) return;
      if (!pw_updating) begin
        pw_pin_on = !pw_pin_on;
        if (!pw_pin_on) begin
          pw_toggle_at += pw_period;
          if (pw_toggle_at > pw_alarm_at) pw_updating = 1'b1;
        end
      end else if (pw_alarm_at > pw_toggle_at) begin
        pw_alarm_at = pw_toggle_at;
        pw_updating = 1'b0;
      end
    end else begin
      if (lvl >= MaxLevel) return;
      if (!pw_updating) begin
        pw_pin_on = !pw_pin_on;
        if (!pw_pin_on) pw_toggle_at += pw_period;
        else if (pw_period > 2 * pw_min) pw_updating = 1'b1;
      end else begin
        off_at = pw_toggle_at + pw_period - pw_min;
        if (pw_alarm_at > off_at) begin
          pw_alarm_at = off_at;
          pw_updating = 1'b0;
        end
      end
    end
  endfunction

  // re-plan for a level at or below half
  function automatic void replan_low(input logic [LevelW-1:0] lvl);
    logic [TimeW-1:0] np;
    if (lvl > 0) begin
      np = (pw_min * MaxLevel) / lvl;
      if (pw_pin_on) begin
        pw_pin_on = 1'b0;
        pw_toggle_at = pw_alarm_at + np - 2 * pw_min;
        pw_updating = pw_toggle_at > pw_alarm_at;
      end else if (!pw_high_mode) begin
        if (pw_prev_level == 0) pw_toggle_at += np;
        else pw_toggle_at += np - pw_period;
        if (pw_toggle_at > pw_alarm_at) begin
          pw_updating = 1'b1;
        end else begin
          if (pw_toggle_at + pw_min > pw_alarm_at) begin
            pw_alarm_at = pw_toggle_at;
          end else begin
            pw_pin_on = 1'b1;
            pw_toggle_at = pw_alarm_at - pw_min;
          end
          pw_updating = 1'b0;
        end
      end else begin
        pw_toggle_at += np - 2 * pw_min;
        if (pw_toggle_at > pw_alarm_at) pw_updating = 1'b1;
        else pw_alarm_at = pw_toggle_at;
      end
      pw_period = np;
    end else begin
      if (pw_pin_on) begin
        pw_pin_on = 1'b0;
        pw_toggle_at = pw_alarm_at - 2 * pw_min;
      end else if (!pw_high_mode) begin
        pw_toggle_at -= pw_period;
      end else begin
        pw_toggle_at -= 2 * pw_min;
      end
    end
    pw_high_mode = 1'b0;
  endfunction

  // re-plan for a level above half
  function automatic void replan_high(input logic [LevelW-1:0] lvl);
    logic [TimeW-1:0] np;
    if (lvl < MaxLevel) begin
      np = (pw_min * MaxLevel) / (MaxLevel - lvl);
      if (!pw_pin_on) begin
        pw_pin_on = 1'b1;
        pw_toggle_at = pw_alarm_at - pw_min;
        pw_updating = np > 2 * pw_min;
      end else if (pw_toggle_at + np > pw_alarm_at + pw_min) begin
        pw_updating = 1'b1;
      end else begin
        if (pw_toggle_at + np > pw_alarm_at) begin
          pw_alarm_at = pw_toggle_at + np - pw_min;
        end else begin
          pw_pin_on = 1'b0;
          pw_toggle_at = pw_alarm_at;
        end
        pw_updating = 1'b0;
      end
      pw_period = np;
    end else if (!pw_pin_on) begin
      pw_pin_on = 1'b1;
      pw_toggle_at = pw_alarm_at - pw_min;
    end
    pw_high_mode = 1'b1;
  endfunction

  function automatic out_beat_t plan_alarm(input in_beat_t beat);
    logic [LevelW-1:0] lvl;
    out_beat_t res;
    lvl = (beat.requested_level > MaxLevel) ? LevelW'(MaxLevel) : beat.requested_level;
    pw_alarm_at += pw_min;
    if (lvl == pw_prev_level) begin
      steady_step(lvl);
    end else begin
      if (lvl <= MaxLevel / 2) replan_low(lvl);
      else replan_high(lvl);
      pw_prev_level = lvl;
    end
    res.pin_level = pw_pin_on;
    res.alarm_time = pw_alarm_at;
    res.alarm_in_future = pw_alarm_at > beat.timer_now;
    return res;
  endfunction

  // random idle burst with valid low
  task automatic idle_burst();
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // valid stays up after a beat until the next beat or an idle stretch
  task automatic send_alarm(input logic [LevelW-1:0] lvl, input logic [TimeW-1:0] now);
    in_beat_t beat;
    idle_burst();
    beat.requested_level = lvl;
    beat.timer_now = now;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_beats.push_back(plan_alarm(beat));
    n_sent++;
  endtask

  // result beat checker and receiver stalls
  initial begin
    out_beat_t exp_beat;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_beats++;
        if (expected_beats.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_data_o.alarm_in_future) n_late++;
          if (out_data_o.pin_level !== exp_beat.pin_level)
            report($sformatf("pin_level got %0b want %0b", out_data_o.pin_level,
                             exp_beat.pin_level));
          if (out_data_o.alarm_time !== exp_beat.alarm_time)
            report($sformatf("alarm_time got %0h want %0h", out_data_o.alarm_time,
                             exp_beat.alarm_time));
          if (out_data_o.alarm_in_future !== exp_beat.alarm_in_future)
            report($sformatf("alarm_in_future got %0b want %0b",
                             out_data_o.alarm_in_future, exp_beat.alarm_in_future));
        end
      end
      // random receiver stall bursts, none when quiet
      if (!quiet && stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(4) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(3, 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_min_pulse(input logic [MinW-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    pw_min = TimeW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LevelW-1:0] rand_level();
    case ($urandom_range(9))
      0: return '0;
      1: return LevelW'(MaxLevel);
      2: return LevelW'($urandom_range(2047, MaxLevel + 1));
      3: return LevelW'(MaxLevel / 2 + $urandom_range(1, 0));
      default: return LevelW'($urandom_range(MaxLevel - 1, 1));
    endcase
  endfunction

  // extremes of level, time and min pulse, and transitions between the regimes
  task automatic test_directed();
    logic [LevelW-1:0] lvls[14] = '{0, 1, 1, 512, 512, 513, 513, 1023, 1024, 1024,
                                   2047, 0, 0, 700};
    foreach (lvls[i]) send_alarm(lvls[i], (i % 2) ? '1 : '0);
    send_alarm(1, pw_alarm_at - 1);
    send_alarm(1, pw_alarm_at + pw_min);
    set_min_pulse(20'hFFFFF);
    send_alarm(1, 0);
    send_alarm(1023, '1);
    send_alarm(2047, 0);
    set_min_pulse(0);
    send_alarm(300, 5);
    send_alarm(800, 5);
    send_alarm(800, 5);
  endtask

  // steady runs at random levels; timer random or near the planned alarm, on either side
  task automatic test_random(input int unsigned count);
    logic [LevelW-1:0] lvl;
    int unsigned run;
    lvl = rand_level();
    for (int unsigned i = 0; i < count; i++) begin
      if (run == 0) begin
        lvl = rand_level();
        run = $urandom_range(12, 1);
      end
      run--;
      case ($urandom_range(3))
        0: send_alarm(lvl, rand_time());
        1: send_alarm(lvl, pw_alarm_at + $urandom_range(3000));
        default: send_alarm(lvl, pw_alarm_at - $urandom_range(3000));
      endcase
    end
  endtask

  initial begin
    pw_min = TimeW'(MinPulseReset);
    {pw_high_mode, pw_pin_on, pw_updating} = '0;
    pw_prev_level = '0;
    {pw_toggle_at, pw_alarm_at, pw_period} = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_min_pulse(1);
    test_random(450);
    set_min_pulse(MinPulseReset);
    test_random(450);
    set_min_pulse(MinW'($urandom_range(1_000_000, 2)));
    test_random(450);
    set_min_pulse(MinW'(1_000_000));
    test_random(300);
    quiet = 1'b1;
    set_min_pulse(20'd77);
    test_random(200);
    drain();
    $display("sent %0d alarm events over a range of pulse settings, %0d results checked",
             n_sent, n_beats);
    $display("%0d results had the alarm ahead of the timer", n_late);
    if (n_errors == 0 && expected_beats.size() == 0)
      $display("min_pulse_variable_period_pwm test passed");
    else
      $display("min_pulse_variable_period_pwm test failed");
    $finish;
  end
endmodule
